/* src/ptq_pkg.sv */
package ptq_pkg;

   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_ADD    = 2'd1;
   localparam logic [1:0] OP_CANCEL = 2'd2;

   localparam logic [1:0] KIND_ACCEPTED = 2'd0;
   localparam logic [1:0] KIND_REFUSED  = 2'd1;
   localparam logic [1:0] KIND_EXPIRED  = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [30:0] delay_ticks;
      logic [30:0] period_ticks;
      logic [31:0] target_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] timer_id;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic wr_en;
      logic set_valid;
      logic clr_valid;
   } tbl_ctl_type;

endpackage

/* src/ptq_table.sv */
module ptq_table
   import ptq_pkg::*;
#(
   parameter int CAPACITY    = 16,
   parameter int ENTRY_WIDTH = 95
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tbl_ctl_type                 ctl,
   input  logic [$clog2(CAPACITY)-1:0] upd_addr,
   input  logic [ENTRY_WIDTH-1:0]      wr_data,
   input  logic [$clog2(CAPACITY)-1:0] rd_addr,
   output logic [ENTRY_WIDTH-1:0]      rd_data,
   output logic [CAPACITY-1:0]         valid_vec,
   output logic                        free_ok,
   output logic [$clog2(CAPACITY)-1:0] free_idx
);

   localparam int AW = $clog2(CAPACITY);

   logic [ENTRY_WIDTH-1:0] mem [CAPACITY];
   logic [ENTRY_WIDTH-1:0] rd_data_ff;
   logic [CAPACITY-1:0]    valid_ff;
   logic [CAPACITY-1:0]    valid_in;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[upd_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctl.set_valid) begin
         valid_in[upd_addr] = 1'b1;
      end
      if (ctl.clr_valid) begin
         valid_in[upd_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      free_ok  = 1'b0;
      free_idx = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_ok  = 1'b1;
            free_idx = AW'(i);
         end
      end
   end

   assign rd_data   = rd_data_ff;
   assign valid_vec = valid_ff;

endmodule

/* src/periodic_timer_queue_unit.sv */
// Add: the registered result appears in the next cycle; the block is ready again at once.
// Cancel: busy while one pass reads every slot from the table memory.
// Tick firing k timers: k scan passes, each ending in one result; one pass when none is due;
// each result needs a full pass over the single memory read port. A stopped tick does nothing.
// Results cannot be stalled. Reset is synchronous: valid bits and time clear at once, the
// identifier counter restarts at 1; the slot memory needs no clearing pass.
module periodic_timer_queue_unit
   import ptq_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int TIME_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    csr_we,
   input  logic    csr_wdata
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   typedef struct packed {
      logic [31:0]           id;
      logic [TIME_WIDTH-1:0] expiry;
      logic [30:0]           period;
   } slot_type;

   localparam int EW = $bits(slot_type);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_EMIT
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [AW-1:0]         rd_idx_ff, rd_idx_in;
   logic                  tick_mode_ff, tick_mode_in;
   logic                  first_ff, first_in;
   logic [CAPACITY-1:0]   pend_ff, pend_in;
   logic                  found_ff, found_in;
   logic [AW-1:0]         best_idx_ff, best_idx_in;
   logic [TIME_WIDTH-1:0] best_age_ff, best_age_in;
   logic [31:0]           best_id_ff, best_id_in;
   logic [30:0]           best_period_ff, best_period_in;
   logic [31:0]           target_ff, target_in;
   logic [TIME_WIDTH-1:0] time_now_ff, time_now_in;
   logic [31:0]           next_id_ff, next_id_in;
   logic                  running_ff, running_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   tbl_ctl_type           ctl;
   logic [AW-1:0]         upd_addr;
   slot_type              wr_slot;
   logic [EW-1:0]         rd_data;
   slot_type              cur;
   logic [CAPACITY-1:0]   valid_vec;
   logic                  free_ok;
   logic [AW-1:0]         free_idx;
   logic [TIME_WIDTH-1:0] age;
   logic                  elig;
   logic [31:0]           id_inc;

   ptq_table #(
      .CAPACITY    (CAPACITY),
      .ENTRY_WIDTH (EW)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .upd_addr  (upd_addr),
      .wr_data   (wr_slot),
      .rd_addr   (cnt_ff[AW-1:0]),
      .rd_data   (rd_data),
      .valid_vec (valid_vec),
      .free_ok   (free_ok),
      .free_idx  (free_idx)
   );

   assign cur    = slot_type'(rd_data);
   assign age    = time_now_ff - cur.expiry;
   assign id_inc = next_id_ff + 32'd1;

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      rd_idx_in      = cnt_ff[AW-1:0];
      tick_mode_in   = tick_mode_ff;
      first_in       = first_ff;
      pend_in        = pend_ff;
      found_in       = found_ff;
      best_idx_in    = best_idx_ff;
      best_age_in    = best_age_ff;
      best_id_in     = best_id_ff;
      best_period_in = best_period_ff;
      target_in      = target_ff;
      time_now_in    = time_now_ff;
      next_id_in     = next_id_ff;
      running_in     = csr_we ? csr_wdata : running_ff;
      rsp_valid_in   = 1'b0;
      rsp_in         = rsp_ff;
      ctl            = '0;
      upd_addr       = best_idx_ff;
      wr_slot        = '0;
      elig           = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_data.op)
                  OP_TICK: begin
                     if (running_ff) begin
                        time_now_in  = time_now_ff + TIME_WIDTH'(1);
                        tick_mode_in = 1'b1;
                        first_in     = 1'b1;
                        found_in     = 1'b0;
                        cnt_in       = '0;
                        state_in     = S_SCAN;
                     end
                  end
                  OP_ADD: begin
                     rsp_valid_in = 1'b1;
                     rsp_in.last  = 1'b1;
                     if (running_ff && free_ok) begin
                        ctl.wr_en      = 1'b1;
                        ctl.set_valid  = 1'b1;
                        upd_addr       = free_idx;
                        wr_slot.id     = next_id_ff;
                        wr_slot.expiry = time_now_ff + TIME_WIDTH'(req_data.delay_ticks);
                        wr_slot.period = req_data.period_ticks;
                        next_id_in     = (id_inc == 32'd0) ? 32'd1 : id_inc;
                        rsp_in.kind     = KIND_ACCEPTED;
                        rsp_in.timer_id = next_id_ff;
                     end else begin
                        rsp_in.kind     = KIND_REFUSED;
                        rsp_in.timer_id = 32'd0;
                     end
                  end
                  OP_CANCEL: begin
                     target_in    = req_data.target_id;
                     tick_mode_in = 1'b0;
                     cnt_in       = '0;
                     state_in     = S_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff != '0) begin
               if (tick_mode_ff) begin
                  elig = first_ff ? (valid_vec[rd_idx_ff] && !age[TIME_WIDTH-1])
                                  : pend_ff[rd_idx_ff];
                  if (first_ff) begin
                     pend_in[rd_idx_ff] = elig;
                  end
                  if (elig && (!found_ff || age > best_age_ff ||
                               (age == best_age_ff && cur.id < best_id_ff))) begin
                     found_in       = 1'b1;
                     best_idx_in    = rd_idx_ff;
                     best_age_in    = age;
                     best_id_in     = cur.id;
                     best_period_in = cur.period;
                  end
               end else if (valid_vec[rd_idx_ff] && cur.id == target_ff) begin
                  ctl.clr_valid = 1'b1;
                  upd_addr      = rd_idx_ff;
               end
               if (cnt_ff == CW'(CAPACITY)) begin
                  state_in = (tick_mode_ff && found_in) ? S_EMIT : S_IDLE;
               end
            end
         end
         S_EMIT: begin
            pend_in[best_idx_ff] = 1'b0;
            rsp_valid_in    = 1'b1;
            rsp_in.kind     = KIND_EXPIRED;
            rsp_in.timer_id = best_id_ff;
            rsp_in.last     = (pend_in == '0);
            if (best_period_ff != 31'd0) begin
               ctl.wr_en      = 1'b1;
               wr_slot.id     = best_id_ff;
               wr_slot.expiry = time_now_ff + TIME_WIDTH'(best_period_ff);
               wr_slot.period = best_period_ff;
            end else begin
               ctl.clr_valid = 1'b1;
            end
            first_in = 1'b0;
            found_in = 1'b0;
            cnt_in   = '0;
            state_in = (pend_in == '0) ? S_IDLE : S_SCAN;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         tick_mode_ff <= 1'b0;
         first_ff     <= 1'b0;
         pend_ff      <= '0;
         found_ff     <= 1'b0;
         time_now_ff  <= '0;
         next_id_ff   <= 32'd1;
         running_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         tick_mode_ff <= tick_mode_in;
         first_ff     <= first_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         time_now_ff  <= time_now_in;
         next_id_ff   <= next_id_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff      <= rd_idx_in;
      best_idx_ff    <= best_idx_in;
      best_age_ff    <= best_age_in;
      best_id_ff     <= best_id_in;
      best_period_ff <= best_period_in;
      target_ff      <= target_in;
      rsp_ff         <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* src/ptq_checker.sv */
module ptq_checker
   import ptq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   a_refused_zero_id : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_REFUSED |-> rsp_data.timer_id == 32'd0)
      else $error("refused add carries a nonzero identifier");

   a_accepted_nonzero_id : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_ACCEPTED |-> rsp_data.timer_id != 32'd0)
      else $error("accepted add carries identifier zero");

   a_add_answers_next : assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.op == OP_ADD |=> rsp_valid && rsp_data.last)
      else $error("add transfer not answered in the next cycle");

   a_cancel_silent : assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.op == OP_CANCEL |=> !rsp_valid)
      else $error("cancel produced a result");

   a_more_expiries_keep_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_EXPIRED && !rsp_data.last |-> busy)
      else $error("block idle before the last expiry of a tick");

endmodule

bind periodic_timer_queue_unit ptq_checker u_ptq_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
